@@ hw/rtl/genotype_break_window_counter_defines.svh @@
// Assertion macros shared by the break window counter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef GENOTYPE_BREAK_WINDOW_COUNTER_DEFINES_SVH
`define GENOTYPE_BREAK_WINDOW_COUNTER_DEFINES_SVH

// same-cycle implication
`define GBWC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GBWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/gbwc_pkg.sv @@
// Package for the break window counter: sizes, cell type, window index helper.
// Depends on nothing.
`timescale 1ns / 1ps

package gbwc_pkg;

    localparam int WINDOW_MAX  = 32;
    localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int WS_W        = 6;
    localparam int ALLELE_W    = 8;
    localparam int IN_TDATA_W  = 4 * ALLELE_W;
    localparam int OUT_TDATA_W = 8;
    localparam logic [WS_W-1:0] WS_RESET = WS_W'(8);

    typedef struct packed {
        logic                open;
        logic [CNT_W-1:0]    cnt;
    } t_cell;

    typedef struct packed {
        logic [ALLELE_W-1:0] b2;
        logic [ALLELE_W-1:0] b1;
        logic [ALLELE_W-1:0] a2;
        logic [ALLELE_W-1:0] a1;
    } t_alleles;

    // position of the window-closing cell; out-of-range sizes clamp
    function automatic logic [IDX_W-1:0] ws_to_idx(input logic [WS_W-1:0] ws);
        if (ws == '0) begin
            return '0;
        end else if (int'(ws) > WINDOW_MAX) begin
            return IDX_W'(WINDOW_MAX - 1);
        end else begin
            return IDX_W'(ws - 1'b1);
        end
    endfunction

endpackage

@@ hw/rtl/gbwc_pair_track.sv @@
// Allele pairing tracker: four pairing flags, run length, break marking.
// Depends on gbwc_pkg.
`timescale 1ns / 1ps

module gbwc_pair_track (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_last,
    input  gbwc_pkg::t_alleles i_alleles,
    output logic              o_mark
);
    import gbwc_pkg::*;

    logic [3:0] r_flags, n_flags;
    logic [1:0] r_run_len, n_run_len;
    logic       r_next_brk, n_next_brk;
    logic       r_started, n_started;
    logic [3:0] w_match;
    logic [3:0] w_f;
    logic [1:0] w_run_inc;

    assign w_match = {i_alleles.a1 == i_alleles.b1, i_alleles.a1 == i_alleles.b2,
                      i_alleles.a2 == i_alleles.b1, i_alleles.a2 == i_alleles.b2};
    assign w_f       = r_flags & w_match;
    assign w_run_inc = (r_run_len == 2'd3) ? r_run_len : r_run_len + 2'd1;

    always_comb begin
        o_mark     = r_next_brk | ~r_started;
        n_flags    = r_flags;
        n_run_len  = w_run_inc;
        n_next_brk = 1'b0;
        n_started  = 1'b1;
        if (i_last) begin
            o_mark    = 1'b1;
            n_flags   = 4'hF;
            n_run_len = '0;
            n_started = 1'b0;
        end else if (w_f != 4'h0) begin
            n_flags = w_f;
        end else if (w_run_inc == 2'd1) begin
            n_next_brk = 1'b1;
            n_flags    = 4'hF;
            n_run_len  = '0;
        end else begin
            o_mark = 1'b1;
            if (w_match == 4'h0) begin
                n_next_brk = 1'b1;
                n_flags    = 4'hF;
                n_run_len  = '0;
            end else begin
                n_flags   = w_match;
                n_run_len = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags    <= 4'hF;
            r_run_len  <= '0;
            r_next_brk <= 1'b0;
            r_started  <= 1'b0;
        end else if (i_step) begin
            r_flags    <= n_flags;
            r_run_len  <= n_run_len;
            r_next_brk <= n_next_brk;
            r_started  <= n_started;
        end
    end

endmodule

@@ hw/rtl/gbwc_cell.sv @@
// One window cell: open flag and break count since the window opened.
// Depends on gbwc_pkg.
`timescale 1ns / 1ps

module gbwc_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  logic           i_clear,
    input  logic           i_mark,
    input  gbwc_pkg::t_cell i_prev,
    output gbwc_pkg::t_cell o_next,
    output gbwc_pkg::t_cell o_cell
);
    import gbwc_pkg::*;

    logic             r_open;
    logic [CNT_W-1:0] r_cnt;

    assign o_next.open = i_prev.open;
    assign o_next.cnt  = i_prev.cnt + CNT_W'(i_mark);
    assign o_cell.open = r_open;
    assign o_cell.cnt  = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (i_clear) begin
            r_open <= 1'b0;
        end else if (i_shift) begin
            r_open <= o_next.open;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_cnt <= o_next.cnt;
        end
    end

endmodule

@@ hw/rtl/genotype_break_window_counter.sv @@
// Break window counter top: pairing tracker, chain of window cells, flush sequencer.
// Depends on gbwc_pkg, gbwc_pair_track, gbwc_cell and the assertion macro header.
// A normal word's result is registered at the accepting edge.
// One word per cycle when not flushing and the result slot is free; a last-marker word flushes
// window_size (clamped 1..32) cells from window end to 0, one per cycle unless a result waits.
// Reset (synchronous, active low) clears all region state; window_size returns to 8.
`timescale 1ns / 1ps
`include "genotype_break_window_counter_defines.svh"

module genotype_break_window_counter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [gbwc_pkg::WS_W-1:0]    i_cfg_wdata,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // [7:0] first_allele_a, [15:8] second_allele_a,
    // [23:16] first_allele_b, [31:24] second_allele_b
    input  logic [gbwc_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    input  logic                         i_s_axis_tuser,  // [0] opens_window
    input  logic                         i_s_axis_tlast,  // last_marker
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [gbwc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata, // [5:0] break_count
    output logic                         o_m_axis_tlast   // last_window
);
    import gbwc_pkg::*;

    typedef enum logic {S_RUN, S_FLUSH} t_state;

    t_state               r_state;
    logic [WS_W-1:0]      r_ws;
    logic [IDX_W-1:0]     r_fp;
    logic                 r_out_valid;
    logic [CNT_W-1:0]     r_out_cnt;
    logic                 r_out_last;

    logic                 w_accept;
    logic                 w_slot_free;
    logic                 w_mark;
    logic                 w_clear;
    logic                 w_fl_adv;
    logic                 w_load_run;
    logic                 w_load_fl;
    logic [IDX_W-1:0]     w_ws_idx;
    logic [WINDOW_MAX-1:0] w_open;
    logic [WINDOW_MAX-1:0] w_low_mask;
    t_cell                w_head;
    t_cell                w_prev [WINDOW_MAX];
    t_cell                w_next [WINDOW_MAX];
    t_cell                w_cell [WINDOW_MAX];

    assign w_ws_idx        = ws_to_idx(r_ws);
    assign w_slot_free     = ~r_out_valid | i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_RUN) & w_slot_free;
    assign w_accept        = i_s_axis_tvalid & o_s_axis_tready;
    assign w_fl_adv        = (r_state == S_FLUSH) & (~w_open[r_fp] | w_slot_free);
    assign w_clear         = w_fl_adv & (r_fp == '0);
    assign w_low_mask      = (WINDOW_MAX'(1) << r_fp) - WINDOW_MAX'(1);
    assign w_load_run      = w_accept & ~i_s_axis_tlast & w_next[w_ws_idx].open;
    assign w_load_fl       = w_fl_adv & w_open[r_fp];

    assign w_head.open = i_s_axis_tuser;
    assign w_head.cnt  = '0;

    gbwc_pair_track u_pair (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_accept),
        .i_last    (i_s_axis_tlast),
        .i_alleles (t_alleles'(i_s_axis_tdata)),
        .o_mark    (w_mark)
    );

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev[g] = w_head;
        end else begin : g_body
            assign w_prev[g] = w_cell[g-1];
        end
        gbwc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept),
            .i_clear (w_clear),
            .i_mark  (w_mark),
            .i_prev  (w_prev[g]),
            .o_next  (w_next[g]),
            .o_cell  (w_cell[g])
        );
        assign w_open[g] = w_cell[g].open;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_ws        <= WS_RESET;
            r_fp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ws <= i_cfg_wdata;
            end
            if (w_load_run | w_load_fl) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_RUN: begin
                    if (w_accept) begin
                        if (i_s_axis_tlast) begin
                            r_state <= S_FLUSH;
                            r_fp    <= w_ws_idx;
                        end else if (w_load_run) begin
                            r_out_cnt   <= w_next[w_ws_idx].cnt;
                            r_out_last  <= 1'b0;
                        end
                    end
                end
                S_FLUSH: begin
                    if (w_fl_adv) begin
                        if (w_open[r_fp]) begin
                            r_out_cnt   <= w_cell[r_fp].cnt;
                            r_out_last  <= ~|(w_open & w_low_mask);
                        end
                        if (r_fp == '0) begin
                            r_state <= S_RUN;
                        end else begin
                            r_fp <= r_fp - 1'b1;
                        end
                    end
                end
                default: r_state <= S_RUN;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_cnt);
    assign o_m_axis_tlast  = r_out_last;

    `GBWC_ASSERT_NEXT(a_last_starts_flush, i_clk, i_rst_n,
        w_accept && i_s_axis_tlast, r_state == S_FLUSH && r_fp == $past(w_ws_idx),
        "last marker did not start the flush at the window end")
    `GBWC_ASSERT_NEXT(a_flush_clears, i_clk, i_rst_n,
        w_clear, r_state == S_RUN && w_open == '0,
        "flush end left open windows")
    `GBWC_ASSERT_NOW(a_count_range, i_clk, i_rst_n,
        r_out_valid, int'(r_out_cnt) <= WINDOW_MAX,
        "break count beyond window capacity")

endmodule

@@ tb/sv/genotype_break_window_counter_tb.sv @@
// Testbench for genotype_break_window_counter: random marker regions, backpressure, window sizes.
// Holds its own break/window predictor and checks every result word in order.
// Depends on gbwc_pkg and the genotype_break_window_counter RTL.
`timescale 1ns / 1ps

module genotype_break_window_counter_tb;

    import gbwc_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int FLUSH_GUARD = 40;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [5:0] count;
        logic       last_win;
    } t_window_result;

    typedef enum int {
        PAIR_A1B1,
        PAIR_A1B2,
        PAIR_A2B1,
        PAIR_A2B2
    } t_pairing;

    logic                   i_clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [WS_W-1:0]        cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   s_tlast;
    logic                   m_valid;
    logic                   m_ready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    // predictor state
    logic [WS_W-1:0]        win_size;
    logic [3:0]             pair_live;
    logic [1:0]             run_count;
    logic                   break_pending;
    logic                   region_open;
    logic [WINDOW_MAX-1:0]  break_hist;
    logic [WINDOW_MAX-1:0]  open_hist;

    t_window_result         expected_windows[$];
    int                     mismatches = 0;
    int                     idle_cycles = 0;
    int                     src_burst = 0;
    int                     sink_burst = 0;
    bit                     src_no_gaps = 0;
    bit                     sink_hold = 0;

    genotype_break_window_counter dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_region();
        pair_live     = 4'hF;
        run_count     = 2'd0;
        break_pending = 1'b0;
        region_open   = 1'b0;
        break_hist    = '0;
        open_hist     = '0;
    endfunction

    function automatic logic [5:0] breaks_in_newest(input int upto);
        logic [5:0] c;
        c = '0;
        for (int i = 0; i <= upto; i++) c += 6'(break_hist[i]);
        return c;
    endfunction

    // updates the predictor with one marker and queues the window counts it closes
    function automatic void predict_windows(input logic [7:0] a1, a2, b1, b2,
                                            input logic opens, input logic last);
        int             ws;
        int             pending;
        int             k;
        logic           mark;
        logic [3:0]     match;
        logic [3:0]     kept;
        t_window_result r;

        ws = (win_size == 0) ? 1 : ((int'(win_size) > WINDOW_MAX) ? WINDOW_MAX : int'(win_size));
        mark = break_pending || !region_open;
        break_pending = 1'b0;
        region_open = 1'b1;
        match = {a1 == b1, a1 == b2, a2 == b1, a2 == b2};

        if (last) begin
            mark = 1'b1;
        end else begin
            kept = pair_live & match;
            if (run_count < 2'd3) run_count++;
            if (kept != 4'h0) begin
                pair_live = kept;
            end else if (run_count == 2'd1) begin
                break_pending = 1'b1;
                pair_live = 4'hF;
                run_count = 2'd0;
            end else begin
                mark = 1'b1;
                if (match == 4'h0) begin
                    break_pending = 1'b1;
                    pair_live = 4'hF;
                    run_count = 2'd0;
                end else begin
                    pair_live = match;
                    run_count = 2'd1;
                end
            end
        end

        break_hist = {break_hist[WINDOW_MAX-2:0], mark};
        open_hist = {open_hist[WINDOW_MAX-2:0], opens};

        if (last) begin
            pending = 0;
            for (int p = 0; p < ws; p++) pending += int'(open_hist[p]);
            k = 0;
            for (int p = ws - 1; p >= 0; p--) begin
                if (open_hist[p]) begin
                    k++;
                    r.count = breaks_in_newest(p);
                    r.last_win = (k == pending);
                    expected_windows = {expected_windows, r};
                end
            end
            clear_region();
        end else if (open_hist[ws-1]) begin
            r.count = breaks_in_newest(ws - 1);
            r.last_win = 1'b0;
            expected_windows = {expected_windows, r};
        end
    endfunction

    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(5, 20);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [7:0] pick_allele();
        if ($urandom_range(0, 3) == 0) return 8'($urandom);
        case ($urandom_range(0, 3))
            0: return 8'h41;
            1: return 8'h43;
            2: return 8'h47;
            default: return 8'h54;
        endcase
    endfunction

    task automatic send_marker(input logic [7:0] a1, a2, b1, b2,
                               input logic opens, input logic last);
        int       gap;
        t_alleles word;
        gap = src_no_gaps ? 0 : draw_gap(src_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        word.a1 = a1;
        word.a2 = a2;
        word.b1 = b1;
        word.b2 = b2;
        s_tdata <= word;
        s_tuser <= opens;
        s_tlast <= last;
        s_valid <= 1'b1;
        do @(posedge i_clk); while (!s_ready);
        predict_windows(a1, a2, b1, b2, opens, last);
        @(negedge i_clk);
    endtask

    // mostly keeps one allele pairing alive so runs grow, with pairing switches and noise
    task automatic send_region(input int len, input int open_pct);
        t_pairing   pair;
        logic [7:0] a1, a2, b1, b2;
        pair = t_pairing'($urandom_range(0, 3));
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 5) == 0) pair = t_pairing'($urandom_range(0, 3));
            a1 = pick_allele();
            a2 = pick_allele();
            b1 = pick_allele();
            b2 = pick_allele();
            if ($urandom_range(0, 9) != 0) begin
                case (pair)
                    PAIR_A1B1: b1 = a1;
                    PAIR_A1B2: b2 = a1;
                    PAIR_A2B1: b1 = a2;
                    default:   b2 = a2;
                endcase
            end
            send_marker(a1, a2, b1, b2, $urandom_range(0, 99) < open_pct, i == len - 1);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_windows.size() != 0) @(negedge i_clk);
        repeat (FLUSH_GUARD) @(negedge i_clk);
    endtask

    task automatic write_window_size(input logic [WS_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        win_size = value;
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        // window size 8 from reset
        send_marker(8'h41, 8'h43, 8'h41, 8'h43, 1'b1, 1'b0);
        send_marker(8'h41, 8'h43, 8'h43, 8'h41, 1'b0, 1'b0); // fail, restart on this word
        send_marker(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0);
        send_marker(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0); // no pairing at all
        send_marker(8'h47, 8'h54, 8'h47, 8'h47, 1'b1, 1'b0);
        send_marker(8'h54, 8'h54, 8'h41, 8'h41, 1'b0, 1'b0);
        send_marker(8'h41, 8'h41, 8'h43, 8'h43, 1'b1, 1'b0); // single-word run fails
        send_marker(8'h43, 8'h43, 8'h43, 8'h43, 1'b0, 1'b0);
        send_marker(8'h43, 8'h41, 8'h43, 8'h41, 1'b1, 1'b0);
        send_marker(8'h43, 8'h41, 8'h41, 8'h43, 1'b0, 1'b0);
        send_marker(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b1); // flush pending windows
        send_marker(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1); // one-word region
        send_marker(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1); // last word, nothing pending
        // window closes exactly on the last word
        for (int i = 0; i < 8; i++)
            send_marker(8'hFF, 8'h00, i[0] ? 8'hFF : 8'h00, 8'h00, i == 0, i == 7);
        drain_results();
    endtask

    task automatic test_window_extremes();
        write_window_size(6'd0);
        send_region(6, 60);
        drain_results();
        write_window_size(6'd63);
        send_region(34, 40);
        drain_results();
        write_window_size(6'd33);
        send_region(8, 50);
        drain_results();
        write_window_size(6'd1);
        send_region(6, 100);
        drain_results();
    endtask

    task automatic test_backpressure();
        write_window_size(6'd1);
        sink_hold = 1'b1;
        src_no_gaps = 1'b1;
        send_region(20, 100);
        src_no_gaps = 1'b0;
        drain_results();
    endtask

    task automatic test_random();
        int items;
        int len;
        items = 0;
        while (items < 12) begin
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 4) == 0)
                    write_window_size(6'($urandom_range(0, 63)));
                else
                    write_window_size(6'($urandom_range(1, 12)));
            end
            len = $urandom_range(1, 12);
            send_region(len, $urandom_range(10, 100));
            drain_results();
            items += len;
        end
    endtask

    // result sink
    initial begin : sink
        int gap;
        m_ready = 1'b0;
        wait (rst_n);
        @(negedge i_clk);
        forever begin
            if (sink_hold) begin
                gap = HOLD_CYCLES;
                sink_hold = 1'b0;
            end else begin
                gap = draw_gap(sink_burst);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_window_result exp_word;
        if (rst_n && m_valid && m_ready) begin
            if (expected_windows.size() == 0) begin
                $error("unexpected result word: break_count=%0d last_window=%0b",
                       m_tdata[5:0], m_tlast);
                mismatches++;
            end else begin
                exp_word = expected_windows.pop_front();
                if (m_tdata[5:0] !== exp_word.count) begin
                    $error("break_count: expected %0d, got %0d", exp_word.count, m_tdata[5:0]);
                    mismatches++;
                end
                if (m_tlast !== exp_word.last_win) begin
                    $error("last_window: expected %0b, got %0b", exp_word.last_win, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("genotype_break_window_counter_tb: FAIL");
            $finish;
        end
    end

    initial begin : run
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        win_size = WS_RESET;
        clear_region();
        repeat (11) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_window_extremes();
        test_backpressure();
        test_random();
        drain_results();
        if (mismatches == 0 && expected_windows.size() == 0) begin
            $display("genotype_break_window_counter_tb: PASS");
        end else begin
            $display("genotype_break_window_counter_tb: FAIL");
        end
        $finish;
    end

endmodule
